[rtl/dcorf_pkg.sv]
// Package for the DCO divider search and RFREQ calculation block.
// Holds widths, constants, register indexes, the HS divider table and the sequencer states.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps

package dcorf_pkg;

    // Field widths
    localparam int TARGET_W   = 30;
    localparam int XTAL_W     = 27;
    localparam int WINDOW_W   = 20;
    localparam int IMAGE_W    = 48;
    localparam int HS_W       = 4;
    localparam int N1_W       = 7;
    localparam int HS_FIELD_W = 3;

    // RFREQ weights: the unit weight sits at bit UNIT_POS, higher bits are left shifts
    localparam int RFREQ_BITS       = 38;
    localparam int UNIT_POS         = 28;
    localparam int SHIFT_UP         = RFREQ_BITS - 1 - UNIT_POS;
    localparam int DEF_WEIGHT_WIDTH = 32;

    // Divider search
    localparam int BASE_W   = 27;
    localparam int NH_W     = 11;
    localparam int DCO_W    = 38;
    localparam int HS_COUNT = 6;
    localparam int HS_IDX_W = 3;
    localparam int N1_MAX   = 127;
    localparam logic [N1_W-1:0] N1_FIRST = N1_W'(2);
    localparam logic [N1_W-1:0] N1_STEP  = N1_W'(2);
    localparam logic [N1_W-1:0] N1_LAST  = N1_W'(N1_MAX - 1);
    localparam logic [HS_IDX_W-1:0] HS_IDX_LAST = HS_IDX_W'(HS_COUNT - 1);
    localparam logic [DCO_W-1:0] DCO_LOW  = DCO_W'(480000000);
    localparam logic [DCO_W-1:0] DCO_HIGH = DCO_W'(560000000);

    // Restoring division runs one quotient bit per cycle
    localparam int DIV_STEPS   = TARGET_W;
    localparam int DIVISOR_TEN = 10;

    // Division by ten as a reciprocal multiply, exact for any 32-bit dividend
    localparam int                 RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // Configuration registers and reset values
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_XTAL   = 1'b0;
    localparam logic REG_WINDOW = 1'b1;
    localparam logic [XTAL_W-1:0]   XTAL_RESET   = XTAL_W'(114292532);
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(50000);

    // Jump kinds reported with every result
    localparam logic KIND_SMALL = 1'b0;
    localparam logic KIND_BIG   = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIFF,
        ST_DIFF_NEG,
        ST_WIN,
        ST_DIV10,
        ST_MUL,
        ST_CMP,
        ST_DIVX,
        ST_GPREP,
        ST_GREEDY,
        ST_DONE
    } state_t;

    // HS divider candidates in search order
    function automatic logic [HS_W-1:0] hs_choice(input logic [HS_IDX_W-1:0] idx);
        logic [HS_W-1:0] hs;
        begin
            unique case (idx)
                3'd0:    hs = 4'd4;
                3'd1:    hs = 4'd5;
                3'd2:    hs = 4'd6;
                3'd3:    hs = 4'd7;
                3'd4:    hs = 4'd9;
                3'd5:    hs = 4'd11;
                default: hs = 4'd4;
            endcase
            return hs;
        end
    endfunction

endpackage

[rtl/dcorf_alu.sv]
// Shared subtract and compare unit of the DCO divider block.
// Used for distance, window compare, division steps and the RFREQ search; needs dcorf_pkg.
`timescale 1ns / 1ps

module dcorf_alu #(
    parameter int WIDTH = dcorf_pkg::DEF_WEIGHT_WIDTH
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             borrow
);

    // One unsigned subtraction; the borrow doubles as the a < b compare.
    always_comb
    begin
        {borrow, diff} = {1'b0, a} - {1'b0, b};
    end

endmodule

[rtl/dcorf_core.sv]
// Sequencer and datapath of the DCO divider search and RFREQ calculation.
// Steps one request through the shared unit in dcorf_alu; needs dcorf_pkg.
`timescale 1ns / 1ps

module dcorf_core #(
    parameter int WEIGHT_WIDTH = dcorf_pkg::DEF_WEIGHT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dcorf_pkg::XTAL_W-1:0]      xtal_freq,
    input  logic [dcorf_pkg::WINDOW_W-1:0]    jump_window,
    input  logic [dcorf_pkg::TARGET_W-1:0]    target_freq,
    input  logic                              req_valid,
    output logic                              req_ready,
    output logic [dcorf_pkg::IMAGE_W-1:0]     register_image,
    output logic                              jump_kind,
    output logic                              repeated,
    output logic                              rsp_valid,
    input  logic                              rsp_ready
);

    localparam int W      = WEIGHT_WIDTH;
    localparam int WSH_W  = W + dcorf_pkg::SHIFT_UP;
    localparam int BIT_W  = $clog2(dcorf_pkg::RFREQ_BITS);
    localparam int CNT_W  = $clog2(dcorf_pkg::DIV_STEPS);
    localparam int TW     = dcorf_pkg::TARGET_W;
    localparam int PROD_W = TW + dcorf_pkg::RECIP_W;

    // Sequencer state
    dcorf_pkg::state_t state_reg, state_next;

    // State kept between requests
    logic [TW-1:0]                      last_target_reg, last_target_next;
    logic [TW-1:0]                      centre_reg, centre_next;
    logic [dcorf_pkg::HS_W-1:0]         hs_reg, hs_next;
    logic [dcorf_pkg::N1_W-1:0]         n1_reg, n1_next;
    logic [W-1:0]                       uw_reg, uw_next;
    logic                               last_kind_reg, last_kind_next;
    logic [dcorf_pkg::IMAGE_W-1:0]      last_image_reg, last_image_next;

    // Loop counters
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic [dcorf_pkg::N1_W-1:0]         n_reg, n_next;
    logic [dcorf_pkg::HS_IDX_W-1:0]     k_reg, k_next;
    logic [BIT_W-1:0]                   bit_reg, bit_next;
    logic                               rsp_valid_reg, rsp_valid_next;

    // Working registers
    logic [TW-1:0]                      f_reg, f_next;
    logic                               rep_reg, rep_next;
    logic [W-1:0]                       acc_reg, acc_next;
    logic [TW-1:0]                      quo_reg, quo_next;
    logic [dcorf_pkg::BASE_W-1:0]       base_reg, base_next;
    logic [dcorf_pkg::NH_W-1:0]         nh_reg, nh_next;
    logic [dcorf_pkg::DCO_W-1:0]        dco_reg, dco_next;
    logic [WSH_W-1:0]                   wsh_reg, wsh_next;
    logic [dcorf_pkg::RFREQ_BITS-1:0]   rfreq_reg, rfreq_next;
    logic [dcorf_pkg::IMAGE_W-1:0]      out_image_reg, out_image_next;
    logic                               out_kind_reg, out_kind_next;
    logic                               out_rep_reg, out_rep_next;

    // Shared unit connections
    logic [W-1:0]                       alu_a, alu_b, alu_diff;
    logic                               alu_borrow;

    // Helpers
    logic [W-1:0]                       div_a;
    logic [TW-1:0]                      quo_shift;
    logic [W-1:0]                       weight;
    logic [dcorf_pkg::N1_W-1:0]         cand_n;
    logic [dcorf_pkg::HS_IDX_W-1:0]     cand_k;
    logic [dcorf_pkg::HS_W-1:0]         hs_sel;
    logic [dcorf_pkg::HS_W-1:0]         hs_off;
    logic [dcorf_pkg::N1_W-1:0]         n1_off;
    logic [PROD_W-1:0]                  div10_prod;

    dcorf_alu #(
        .WIDTH (W)
    ) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    assign req_ready      = (state_reg == dcorf_pkg::ST_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign register_image = out_image_reg;
    assign jump_kind      = out_kind_reg;
    assign repeated       = out_rep_reg;

    // Partial remainder shifted left with the next dividend bit.
    assign div_a     = {acc_reg[W-2:0], quo_reg[TW-1]};
    assign quo_shift = {quo_reg[TW-2:0], ~alu_borrow};
    assign weight    = wsh_reg[W-1:0];
    assign hs_sel    = dcorf_pkg::hs_choice(k_reg);
    assign hs_off    = hs_reg - dcorf_pkg::HS_W'(4);
    assign n1_off    = n1_reg - dcorf_pkg::N1_W'(1);

    // Target times the reciprocal of ten; the quotient sits above RECIP_SHIFT.
    assign div10_prod = PROD_W'(f_reg) * PROD_W'(dcorf_pkg::RECIP_TEN);

    // Next divider candidate: HS runs in the inner loop, N1 steps by two.
    always_comb
    begin
        if (k_reg == dcorf_pkg::HS_IDX_LAST)
        begin
            cand_n = n_reg + dcorf_pkg::N1_STEP;
            cand_k = '0;
        end
        else
        begin
            cand_n = n_reg;
            cand_k = k_reg + dcorf_pkg::HS_IDX_W'(1);
        end
    end

    // Next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        last_target_next = last_target_reg;
        centre_next      = centre_reg;
        hs_next          = hs_reg;
        n1_next          = n1_reg;
        uw_next          = uw_reg;
        last_kind_next   = last_kind_reg;
        last_image_next  = last_image_reg;
        cnt_next         = cnt_reg;
        n_next           = n_reg;
        k_next           = k_reg;
        bit_next         = bit_reg;
        f_next           = f_reg;
        rep_next         = rep_reg;
        acc_next         = acc_reg;
        quo_next         = quo_reg;
        base_next        = base_reg;
        nh_next          = nh_reg;
        dco_next         = dco_reg;
        wsh_next         = wsh_reg;
        rfreq_next       = rfreq_reg;
        out_image_next   = out_image_reg;
        out_kind_next    = out_kind_reg;
        out_rep_next     = out_rep_reg;
        alu_a            = '0;
        alu_b            = '0;

        // The receiver takes the pending result.
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            dcorf_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    f_next     = target_freq;
                    state_next = dcorf_pkg::ST_CHECK;
                end
            end

            // A repeated target answers with the stored result.
            dcorf_pkg::ST_CHECK:
            begin
                if (f_reg == last_target_reg)
                begin
                    rep_next   = 1'b1;
                    state_next = dcorf_pkg::ST_DONE;
                end
                else
                begin
                    rep_next   = 1'b0;
                    state_next = dcorf_pkg::ST_DIFF;
                end
            end

            // Distance to the centre, taken in whichever order gives no borrow.
            dcorf_pkg::ST_DIFF:
            begin
                alu_a = W'(centre_reg);
                alu_b = W'(f_reg);
                if (alu_borrow)
                begin
                    state_next = dcorf_pkg::ST_DIFF_NEG;
                end
                else
                begin
                    acc_next   = alu_diff;
                    state_next = dcorf_pkg::ST_WIN;
                end
            end

            dcorf_pkg::ST_DIFF_NEG:
            begin
                alu_a      = W'(f_reg);
                alu_b      = W'(centre_reg);
                acc_next   = alu_diff;
                state_next = dcorf_pkg::ST_WIN;
            end

            // Small jump keeps the dividers; a big jump starts with target / 10.
            dcorf_pkg::ST_WIN:
            begin
                alu_a = acc_reg;
                alu_b = W'(jump_window);
                if (alu_borrow)
                begin
                    last_kind_next = dcorf_pkg::KIND_SMALL;
                    state_next     = dcorf_pkg::ST_GPREP;
                end
                else
                begin
                    last_kind_next = dcorf_pkg::KIND_BIG;
                    centre_next    = f_reg;
                    state_next     = dcorf_pkg::ST_DIV10;
                end
            end

            // Take target / 10 from the reciprocal product and load the first pair.
            dcorf_pkg::ST_DIV10:
            begin
                base_next  = div10_prod[dcorf_pkg::RECIP_SHIFT +: dcorf_pkg::BASE_W];
                n_next     = dcorf_pkg::N1_FIRST;
                k_next     = '0;
                nh_next    = dcorf_pkg::NH_W'(dcorf_pkg::N1_FIRST)
                           * dcorf_pkg::NH_W'(dcorf_pkg::hs_choice('0));
                state_next = dcorf_pkg::ST_MUL;
            end

            // DCO frequency of the current candidate pair.
            dcorf_pkg::ST_MUL:
            begin
                dco_next   = dcorf_pkg::DCO_W'(base_reg) * dcorf_pkg::DCO_W'(nh_reg);
                state_next = dcorf_pkg::ST_CMP;
            end

            dcorf_pkg::ST_CMP:
            begin
                if ((dco_reg > dcorf_pkg::DCO_LOW) && (dco_reg < dcorf_pkg::DCO_HIGH))
                begin
                    hs_next    = hs_sel;
                    n1_next    = n_reg;
                    acc_next   = '0;
                    quo_next   = TW'(xtal_freq);
                    cnt_next   = '0;
                    state_next = dcorf_pkg::ST_DIVX;
                end
                else if ((n_reg == dcorf_pkg::N1_LAST) && (k_reg == dcorf_pkg::HS_IDX_LAST))
                begin
                    // No pair fits the band: old dividers and weight stay.
                    state_next = dcorf_pkg::ST_GPREP;
                end
                else
                begin
                    n_next     = cand_n;
                    k_next     = cand_k;
                    nh_next    = dcorf_pkg::NH_W'(cand_n)
                               * dcorf_pkg::NH_W'(dcorf_pkg::hs_choice(cand_k));
                    state_next = dcorf_pkg::ST_MUL;
                end
            end

            // Unit weight = crystal / (HS * N1).
            dcorf_pkg::ST_DIVX:
            begin
                alu_a    = div_a;
                alu_b    = W'(nh_reg);
                acc_next = alu_borrow ? div_a : alu_diff;
                quo_next = quo_shift;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(dcorf_pkg::DIV_STEPS - 1))
                begin
                    uw_next    = W'(quo_shift);
                    state_next = dcorf_pkg::ST_GPREP;
                end
            end

            // Top weight is the unit weight shifted up, wrapped to the weight width.
            dcorf_pkg::ST_GPREP:
            begin
                acc_next   = W'(f_reg);
                wsh_next   = WSH_W'(uw_reg) << dcorf_pkg::SHIFT_UP;
                bit_next   = BIT_W'(dcorf_pkg::RFREQ_BITS - 1);
                rfreq_next = '0;
                state_next = dcorf_pkg::ST_GREEDY;
            end

            // One RFREQ bit per cycle, highest first; a zero weight ends the search.
            dcorf_pkg::ST_GREEDY:
            begin
                alu_a = acc_reg;
                alu_b = weight;
                if (weight != '0)
                begin
                    if (!alu_borrow)
                    begin
                        acc_next   = alu_diff;
                        rfreq_next = rfreq_reg
                                   | (dcorf_pkg::RFREQ_BITS'(1) << bit_reg);
                    end
                    wsh_next = wsh_reg >> 1;
                    bit_next = bit_reg - BIT_W'(1);
                end
                if ((weight == '0) || (bit_reg == '0))
                begin
                    last_image_next  = {hs_off[dcorf_pkg::HS_FIELD_W-1:0], n1_off, rfreq_next};
                    last_target_next = f_reg;
                    state_next       = dcorf_pkg::ST_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            dcorf_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    out_image_next = last_image_reg;
                    out_kind_next  = last_kind_reg;
                    out_rep_next   = rep_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = dcorf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dcorf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dcorf_pkg::ST_IDLE;
            last_target_reg <= '0;
            centre_reg      <= '0;
            hs_reg          <= '0;
            n1_reg          <= '0;
            uw_reg          <= '0;
            last_kind_reg   <= dcorf_pkg::KIND_SMALL;
            last_image_reg  <= '0;
            cnt_reg         <= '0;
            n_reg           <= '0;
            k_reg           <= '0;
            bit_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_target_reg <= last_target_next;
            centre_reg      <= centre_next;
            hs_reg          <= hs_next;
            n1_reg          <= n1_next;
            uw_reg          <= uw_next;
            last_kind_reg   <= last_kind_next;
            last_image_reg  <= last_image_next;
            cnt_reg         <= cnt_next;
            n_reg           <= n_next;
            k_reg           <= k_next;
            bit_reg         <= bit_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        f_reg         <= f_next;
        rep_reg       <= rep_next;
        acc_reg       <= acc_next;
        quo_reg       <= quo_next;
        base_reg      <= base_next;
        nh_reg        <= nh_next;
        dco_reg       <= dco_next;
        wsh_reg       <= wsh_next;
        rfreq_reg     <= rfreq_next;
        out_image_reg <= out_image_next;
        out_kind_reg  <= out_kind_next;
        out_rep_reg   <= out_rep_next;
    end

endmodule

[rtl/dco_divider_rfreq_calc_top.sv]
// Top level of the DCO divider search and RFREQ calculation block.
// Holds the APB configuration registers and instantiates dcorf_core; needs dcorf_pkg.
`timescale 1ns / 1ps

// Usage:
// A request carries target_freq in hertz on req_valid / req_ready. Each request
// gives one result on rsp_valid / rsp_ready: the 48-bit image of registers 7 to 12,
// the jump kind and the repeated flag.
// The block works on one request at a time; req_ready is high only while it is idle.
// Steps from acceptance until the result sits in the output register:
//   repeated target:  check, then done.
//   small jump:       check, distance, window compare, weight setup, then the RFREQ bits.
//   big jump:         as a small jump, plus target / 10, each divider pair tried and the division.
// The shared subtract unit does one quotient bit per cycle in the 30-step division of the
// crystal frequency and one RFREQ bit per cycle; each HS/N1 candidate passes a multiply
// and a compare state, and target / 10 is one reciprocal multiply.
// The core returns to idle as the result is loaded and takes the next request even while
// that result still waits for rsp_ready.
// If the receiver stalls, a finished result waits in the output register and the
// core holds the following one until the register frees.
// Reset (rst_n, asynchronous) clears all kept state and loads the default crystal
// frequency and jump window. pready is always high; writes land on the access cycle.
module dco_divider_rfreq_calc_top #(
    parameter int WEIGHT_WIDTH = dcorf_pkg::DEF_WEIGHT_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dcorf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dcorf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dcorf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic [dcorf_pkg::TARGET_W-1:0]      target_freq,
    input  logic                                req_valid,
    output logic                                req_ready,
    output logic [dcorf_pkg::IMAGE_W-1:0]       register_image,
    output logic                                jump_kind,
    output logic                                repeated,
    output logic                                rsp_valid,
    input  logic                                rsp_ready
);

    logic [dcorf_pkg::XTAL_W-1:0]   xtal_reg, xtal_next;
    logic [dcorf_pkg::WINDOW_W-1:0] window_reg, window_next;
    logic                           reg_sel;
    logic                           cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[dcorf_pkg::REG_SEL_BIT];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register write decode
    always_comb
    begin
        xtal_next   = xtal_reg;
        window_next = window_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                dcorf_pkg::REG_XTAL:   xtal_next   = pwdata[dcorf_pkg::XTAL_W-1:0];
                dcorf_pkg::REG_WINDOW: window_next = pwdata[dcorf_pkg::WINDOW_W-1:0];
                default:               xtal_next   = xtal_reg;
            endcase
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (reg_sel)
            dcorf_pkg::REG_XTAL:   prdata = dcorf_pkg::APB_DATA_W'(xtal_reg);
            dcorf_pkg::REG_WINDOW: prdata = dcorf_pkg::APB_DATA_W'(window_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xtal_reg   <= dcorf_pkg::XTAL_RESET;
            window_reg <= dcorf_pkg::WINDOW_RESET;
        end
        else
        begin
            xtal_reg   <= xtal_next;
            window_reg <= window_next;
        end
    end

    dcorf_core #(
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .xtal_freq      (xtal_reg),
        .jump_window    (window_reg),
        .target_freq    (target_freq),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .register_image (register_image),
        .jump_kind      (jump_kind),
        .repeated       (repeated),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready)
    );

    // An accepted request makes the core busy on the next cycle.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("core still ready after accepting a request");

    // The core only leaves idle by accepting a request.
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(req_valid))
        else $error("ready dropped without a request");

    // A new result enters the output register exactly as the core returns to idle.
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $rose(req_ready))
        else $error("result loaded while the core was not finishing");

endmodule

[bench/dco_divider_rfreq_calc_top_tb.sv]
// Self-checking testbench for dco_divider_rfreq_calc_top: directed and random tuning requests.
// It predicts every register image in SystemVerilog and compares the results field by field.
// Depends on rtl/dcorf_pkg.sv and rtl/dco_divider_rfreq_calc_top.sv.
`timescale 1ns / 1ps

module dco_divider_rfreq_calc_top_tb;

    import dcorf_pkg::*;

    // One result of the block, as the checker compares it.
    typedef struct packed {
        logic [IMAGE_W-1:0] image;
        logic               kind;
        logic               rep;
    } dco_result_t;

    // One row of the directed table; fixed rows carry a hand-written expectation.
    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic                fixed;
        dco_result_t         res;
    } tune_row_t;

    localparam int          CLK_HALF       = 5;
    localparam int          LIMIT_CYCLES   = 4_000_000;
    localparam int          DRAIN_CYCLES   = 900;
    localparam int          RAND_PER_PHASE = 75;
    localparam int          ZERO_XTAL_ITEMS = 30;
    localparam int          TABLE_PHASES   = 5;
    localparam int          PHASES         = 8;
    localparam int          DIRECTED_N     = 24;
    localparam int          HS_OFFSET      = 4;
    localparam longint      TARGET_MAX     = (longint'(1) << TARGET_W) - 1;
    localparam dco_result_t NO_RESULT      = '0;

    // Dividers still zero wrap to an HS field of 4 and an N1 field of 127, with RFREQ zero.
    localparam logic [IMAGE_W-1:0] IMG_NO_DIV = 48'h9FC0_0000_0000;

    localparam logic [APB_ADDR_W-1:0] XTAL_ADDR   = {REG_XTAL, 2'b00};
    localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};

    // HS candidates in search order, lowest nibble first.
    localparam logic [HS_COUNT*HS_W-1:0] HS_LIST = {4'd11, 4'd9, 4'd7, 4'd6, 4'd5, 4'd4};

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   psel        = 1'b0;
    logic                   penable     = 1'b0;
    logic                   pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr       = '0;
    logic [APB_DATA_W-1:0]  pwdata      = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic [TARGET_W-1:0]    target_freq = '0;
    logic                   req_valid   = 1'b0;
    logic                   req_ready;
    logic [IMAGE_W-1:0]     register_image;
    logic                   jump_kind;
    logic                   repeated;
    logic                   rsp_valid;
    logic                   rsp_ready   = 1'b0;

    // Configuration as last programmed.
    logic [XTAL_W-1:0]      cfg_xtal    = XTAL_RESET;
    logic [WINDOW_W-1:0]    cfg_window  = WINDOW_RESET;

    // Tuning state of the predicted oscillator.
    logic [TARGET_W-1:0]         tune_last_target = '0;
    logic [TARGET_W-1:0]         tune_centre      = '0;
    logic [HS_W-1:0]             tune_hs          = '0;
    logic [N1_W-1:0]             tune_n1          = '0;
    logic [DEF_WEIGHT_WIDTH-1:0] tune_weight      = '0;
    logic                        tune_kind        = KIND_SMALL;
    logic [IMAGE_W-1:0]          tune_image       = '0;

    dco_result_t pending_images [$];
    int          errors       = 0;
    int          cycles       = 0;
    int          burst_left   = 0;
    int          n_requests   = 0;
    int          n_big        = 0;
    int          n_small      = 0;
    int          n_repeat     = 0;

    tune_row_t directed_rows [DIRECTED_N] = '{
        '{30'd0,             1'b1, '{48'h0,      KIND_SMALL, 1'b1}},
        '{30'd1,             1'b1, '{IMG_NO_DIV, KIND_SMALL, 1'b0}},
        '{30'd1,             1'b1, '{IMG_NO_DIV, KIND_SMALL, 1'b1}},
        '{30'd1_000_000_000, 1'b1, '{IMG_NO_DIV, KIND_BIG,   1'b0}},
        '{30'h3FFF_FFFF,     1'b1, '{IMG_NO_DIV, KIND_BIG,   1'b0}},
        '{30'h3FFF_FFFF,     1'b1, '{IMG_NO_DIV, KIND_BIG,   1'b1}},
        '{30'd14_000_000,    1'b0, NO_RESULT},
        '{30'd14_000_100,    1'b0, NO_RESULT},
        '{30'd14_049_999,    1'b0, NO_RESULT},
        '{30'd14_050_000,    1'b0, NO_RESULT},
        '{30'd14_000_001,    1'b0, NO_RESULT},
        '{30'd14_000_001,    1'b0, NO_RESULT},
        '{30'd13_950_000,    1'b0, NO_RESULT},
        '{30'd300_000,       1'b0, NO_RESULT},
        '{30'd3_500_000,     1'b0, NO_RESULT},
        '{30'd7_000_000,     1'b0, NO_RESULT},
        '{30'd100_000_000,   1'b0, NO_RESULT},
        '{30'd160_000_000,   1'b0, NO_RESULT},
        '{30'd500_000_000,   1'b0, NO_RESULT},
        '{30'd699_999_990,   1'b0, NO_RESULT},
        '{30'd700_000_000,   1'b0, NO_RESULT},
        '{30'h2AAA_AAAA,     1'b0, NO_RESULT},
        '{30'h1555_5555,     1'b0, NO_RESULT},
        '{30'd0,             1'b0, NO_RESULT}
    };

    // Register settings of the first phases; the remaining phases pick their own.
    int unsigned phase_xtal   [TABLE_PHASES] = '{100_000_000, 130_000_000, 134_217_727,
                                                 0, 114_292_532};
    int unsigned phase_window [TABLE_PHASES] = '{0, 1_000_000, 1_048_575, 50_000, 1};

    dco_divider_rfreq_calc_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .target_freq    (target_freq),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .register_image (register_image),
        .jump_kind      (jump_kind),
        .repeated       (repeated),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Predict the result of one tuning request and advance the predicted state.
    function automatic dco_result_t predict_tuning(input logic [TARGET_W-1:0] f);
        dco_result_t                 res;
        logic [TARGET_W-1:0]         delta;
        logic [63:0]                 base;
        logic [63:0]                 dco;
        logic [63:0]                 remaining;
        logic [DEF_WEIGHT_WIDTH-1:0] wt;
        logic [RFREQ_BITS-1:0]       rfreq;
        logic [HS_W-1:0]             hs;
        logic [HS_FIELD_W-1:0]       hs_field;
        logic [N1_W-1:0]             n1_field;
        bit                          found;
        bit                          stop;
        n_requests++;
        if (f == tune_last_target)
        begin
            n_repeat++;
            res.image = tune_image;
            res.kind  = tune_kind;
            res.rep   = 1'b1;
            return res;
        end

        delta = (tune_centre > f) ? tune_centre - f : f - tune_centre;
        if (delta < cfg_window)
        begin
            n_small++;
            tune_kind = KIND_SMALL;
        end
        else
        begin
            // First even N1, then HS in table order, whose DCO falls strictly inside the band.
            n_big++;
            base  = 64'(f / DIVISOR_TEN);
            found = 0;
            for (int n = N1_FIRST; n <= N1_MAX && !found; n += N1_STEP)
            begin
                for (int k = 0; k < HS_COUNT && !found; k++)
                begin
                    hs  = HS_LIST[k*HS_W +: HS_W];
                    dco = base * 64'(n) * 64'(hs);
                    if (dco > DCO_LOW && dco < DCO_HIGH)
                    begin
                        found       = 1;
                        tune_hs     = hs;
                        tune_n1     = N1_W'(n);
                        tune_weight = DEF_WEIGHT_WIDTH'(64'(cfg_xtal) / (64'(hs) * 64'(n)));
                    end
                end
            end
            tune_centre = f;
            tune_kind   = KIND_BIG;
        end

        // Greedy RFREQ: high weights wrap at the weight width, the first zero weight ends it.
        rfreq     = '0;
        remaining = 64'(f);
        stop      = 0;
        for (int i = RFREQ_BITS - 1; i >= 0 && !stop; i--)
        begin
            if (i >= UNIT_POS)
                wt = tune_weight << (i - UNIT_POS);
            else
                wt = tune_weight >> (UNIT_POS - i);
            if (wt == 0)
                stop = 1;
            else if (remaining >= 64'(wt))
            begin
                remaining = remaining - 64'(wt);
                rfreq[i]  = 1'b1;
            end
        end

        hs_field         = HS_FIELD_W'(tune_hs - HS_W'(HS_OFFSET));
        n1_field         = tune_n1 - N1_W'(1);
        tune_image       = {hs_field, n1_field, rfreq};
        tune_last_target = f;
        res.image        = tune_image;
        res.kind         = tune_kind;
        res.rep          = 1'b0;
        return res;
    endfunction

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write both registers, read them back and adopt them in the predictor.
    task automatic program_tuning(input logic [XTAL_W-1:0] xtal, input logic [WINDOW_W-1:0] window);
        logic [APB_DATA_W-1:0] rd;
        apb_write(XTAL_ADDR, APB_DATA_W'(xtal));
        apb_write(WINDOW_ADDR, APB_DATA_W'(window));
        apb_read(XTAL_ADDR, rd);
        if (rd !== APB_DATA_W'(xtal))
        begin
            $error("xtal_freq: expected %0d, got %0d", xtal, rd);
            errors++;
        end
        apb_read(WINDOW_ADDR, rd);
        if (rd !== APB_DATA_W'(window))
        begin
            $error("jump_window: expected %0d, got %0d", window, rd);
            errors++;
        end
        cfg_xtal   = xtal;
        cfg_window = window;
    endtask

    // Offer one request after an optional burst gap and record what it must produce.
    task automatic send_target(input logic [TARGET_W-1:0] f, input bit fixed,
                               input dco_result_t fixed_res);
        dco_result_t res;
        int          gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        target_freq <= f;
        req_valid   <= 1'b1;
        do @(posedge clk); while (!req_ready);
        res = predict_tuning(f);
        pending_images.push_back(fixed ? fixed_res : res);
    endtask

    // Let the block finish every request before the registers change.
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_images.size() != 0) @(posedge clk);
    endtask

    // Receiver: stretches of random length, each with its own acceptance odds.
    initial
    begin : rsp_stall
        int odds;
        int span;
        forever
        begin
            odds = $urandom_range(1, 8);
            span = $urandom_range(1, 60);
            repeat (span)
            begin
                @(posedge clk);
                rsp_ready <= ($urandom_range(0, 7) < odds);
            end
        end
    end

    // Compare each accepted result with the oldest pending expectation.
    always @(posedge clk)
    begin : rsp_check
        dco_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_images.size() == 0)
            begin
                $error("result with no request pending: register_image %h", register_image);
                errors++;
            end
            else
            begin
                want = pending_images.pop_front();
                if (register_image !== want.image)
                begin
                    $error("register_image: expected %h, got %h", want.image, register_image);
                    errors++;
                end
                if (jump_kind !== want.kind)
                begin
                    $error("jump_kind: expected %0d, got %0d", want.kind, jump_kind);
                    errors++;
                end
                if (repeated !== want.rep)
                begin
                    $error("repeated: expected %0d, got %0d", want.rep, repeated);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles with %0d results pending.",
                     cycles, pending_images.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases over several settings.
    initial
    begin : main_seq
        longint      t;
        longint      off;
        int          pick;
        int          count;
        logic [XTAL_W-1:0]   xtal;
        logic [WINDOW_W-1:0] window;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset settings.
        for (int r = 0; r < DIRECTED_N; r++)
            send_target(directed_rows[r].target, directed_rows[r].fixed, directed_rows[r].res);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < TABLE_PHASES)
            begin
                xtal   = XTAL_W'(phase_xtal[p]);
                window = WINDOW_W'(phase_window[p]);
            end
            else
            begin
                xtal   = XTAL_W'($urandom_range(100_000_000, 130_000_000));
                window = WINDOW_W'($urandom_range(0, 1_000_000));
            end
            program_tuning(xtal, window);
            count = (xtal == 0) ? ZERO_XTAL_ITEMS : RAND_PER_PHASE;

            for (int i = 0; i < count; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    t = longint'(tune_last_target);
                else if (pick < 40)
                begin
                    // Small move inside the window around the centre.
                    off = (cfg_window == 0) ? 0 : longint'($urandom_range(0, cfg_window - 1));
                    t = longint'(tune_centre) + ($urandom_range(0, 1) ? off : -off);
                end
                else if (pick < 50)
                begin
                    // Right at the window edge, one hertz either side.
                    off = longint'(cfg_window) + longint'($urandom_range(0, 2)) - 1;
                    t = longint'(tune_centre) + ($urandom_range(0, 1) ? off : -off);
                end
                else if (pick < 85)
                    t = longint'($urandom_range(1_000_000, 200_000_000));
                else if (pick < 93)
                    t = longint'($urandom) & TARGET_MAX;
                else
                    t = longint'($urandom_range(0, 1_000_000));
                if (t < 0)
                    t = 0;
                if (t > TARGET_MAX)
                    t = TARGET_MAX;
                send_target(TARGET_W'(t), 1'b0, NO_RESULT);
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d tuning requests over %0d register settings:", n_requests, PHASES + 1);
        $display("%0d big jumps, %0d small jumps and %0d repeats; %0d mismatches.",
                 n_big, n_small, n_repeat, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/dcorf_pkg.sv
rtl/dcorf_alu.sv
rtl/dcorf_core.sv
rtl/dco_divider_rfreq_calc_top.sv
bench/dco_divider_rfreq_calc_top_tb.sv
